// ===== hdl/thrl_pkg.sv =====
`timescale 1ns / 1ps

package thrl_pkg;

   // Number of records in the ring.
   localparam int LOG_DEPTH = 64;
   localparam int PTR_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

   // Limits of a valid minute timestamp.
   localparam logic [7:0] YEAR_MAX   = 8'd99;
   localparam logic [7:0] MONTH_MAX  = 8'd12;
   localparam logic [7:0] DAY_MAX    = 8'd31;
   localparam logic [7:0] HOUR_MAX   = 8'd23;
   localparam logic [7:0] MINUTE_MAX = 8'd59;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic [31:0] total;
      logic [7:0]  year;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [7:0]  hour;
      logic [7:0]  minute;
   } rec_type;

   typedef struct packed {
      logic    en;
      ptr_type addr;
      rec_type rec;
   } wr_type;

   typedef enum logic [1:0] {
      OP_SAVE  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SAVE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Next ring position with wrap.
   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(LOG_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   // True when every timestamp field lies in its calendar range.
   function automatic logic rec_ok(input rec_type r);
      logic ok;
      ok = (r.year <= YEAR_MAX)
         && (r.month != 8'd0) && (r.month <= MONTH_MAX)
         && (r.day != 8'd0) && (r.day <= DAY_MAX)
         && (r.hour <= HOUR_MAX)
         && (r.minute <= MINUTE_MAX);
      return ok;
   endfunction

endpackage

// ===== hdl/thrl_store.sv =====
`timescale 1ns / 1ps

module thrl_store (
   input  logic             clock,
   input  logic             reset,
   input  thrl_pkg::ptr_type rd_addr,
   output thrl_pkg::rec_type rd_rec,
   input  thrl_pkg::wr_type  wr,
   input  logic             clr_en,
   input  thrl_pkg::ptr_type clr_addr
);
   import thrl_pkg::*;

   rec_type               mem [LOG_DEPTH];
   logic [LOG_DEPTH-1:0]  vld_ff;
   rec_type               rd_data_ff;
   logic                  rd_vld_ff;

   // Record array with a registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.rec;
      end
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

   // An entry that is not valid reads as an all-zero record.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (clr_en) begin
            vld_ff[clr_addr] <= 1'b0;
         end
      end
   end

   assign rd_rec = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== hdl/timestamped_history_ring_log_unit.sv =====
`timescale 1ns / 1ps

// Ring log of meter records, each a 32-bit total with a minute timestamp.
// A save reads the newest entry and, unless its total matches, advances the
// save pointer and writes the new record. A clear drops the entry at the
// read pointer. A read walks the ring from the read pointer, one entry per
// cycle from the single registered read port of the record memory, and stops
// at the first record with a valid timestamp or after it has examined the
// save position. The result sits in an output register and the next request
// is taken while it waits. After reset every entry reads as zero at once.
module timestamped_history_ring_log_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_total_in,
   input  logic [7:0]  req_year_in,
   input  logic [7:0]  req_month_in,
   input  logic [7:0]  req_day_in,
   input  logic [7:0]  req_hour_in,
   input  logic [7:0]  req_minute_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic        rsp_stored,
   output logic [31:0] rsp_total_out,
   output logic [7:0]  rsp_year_out,
   output logic [7:0]  rsp_month_out,
   output logic [7:0]  rsp_day_out,
   output logic [7:0]  rsp_hour_out,
   output logic [7:0]  rsp_minute_out
);
   import thrl_pkg::*;

   state_type state_ff, state_in;
   rec_type   req_rec_ff;
   ptr_type   addr_ff;
   ptr_type   save_ptr_ff, save_ptr_in;
   ptr_type   read_ptr_ff, read_ptr_in;
   logic      rsp_valid_ff;
   logic      rsp_found_ff;
   logic      rsp_stored_ff;
   rec_type   rsp_rec_ff;

   ptr_type   rd_addr;
   rec_type   cur_rec;
   wr_type    wr;
   logic      clr_en;
   logic      req_accept;
   logic      out_free;
   logic      load;
   logic      ld_found;
   logic      ld_stored;
   rec_type   ld_rec;

   // The store reads back a zeroed record for entries that were never written
   // or that a clear has dropped.
   thrl_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_rec   (cur_rec),
      .wr       (wr),
      .clr_en   (clr_en),
      .clr_addr (read_ptr_ff)
   );

   assign req_accept = req_valid && !req_stall;
   // The output register can take a new result when it is empty or being drained.
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         save_ptr_ff <= '0;
         read_ptr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         save_ptr_ff <= save_ptr_in;
         read_ptr_ff <= read_ptr_in;
      end
   end

   // The read address is held in a register so that a stalled completion
   // keeps presenting the same record.
   always_ff @(posedge clock) begin
      addr_ff <= rd_addr;
      if (req_accept) begin
         req_rec_ff.total  <= req_total_in;
         req_rec_ff.year   <= req_year_in;
         req_rec_ff.month  <= req_month_in;
         req_rec_ff.day    <= req_day_in;
         req_rec_ff.hour   <= req_hour_in;
         req_rec_ff.minute <= req_minute_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      save_ptr_in = save_ptr_ff;
      read_ptr_in = read_ptr_ff;
      rd_addr     = addr_ff;
      wr          = '0;
      clr_en      = 1'b0;
      load        = 1'b0;
      ld_found    = 1'b0;
      ld_stored   = 1'b0;
      ld_rec      = '0;
      req_stall   = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  OP_SAVE: begin
                     // Fetch the newest entry for the duplicate check.
                     rd_addr  = save_ptr_ff;
                     state_in = ST_SAVE;
                  end
                  OP_READ: begin
                     rd_addr  = read_ptr_ff;
                     state_in = ST_SCAN;
                  end
                  OP_CLEAR: begin
                     clr_en   = 1'b1;
                     state_in = ST_DONE;
                  end
                  default: begin
                     // The unused code changes nothing and answers with zeros.
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SAVE: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               if (cur_rec.total != req_rec_ff.total) begin
                  wr.en       = 1'b1;
                  wr.addr     = ptr_next(save_ptr_ff);
                  wr.rec      = req_rec_ff;
                  save_ptr_in = ptr_next(save_ptr_ff);
                  ld_stored   = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (rec_ok(cur_rec)) begin
               if (out_free) begin
                  load        = 1'b1;
                  ld_found    = 1'b1;
                  ld_rec      = cur_rec;
                  read_ptr_in = addr_ff;
                  state_in    = ST_IDLE;
               end
            end else if (addr_ff == save_ptr_ff) begin
               // The save position was the last entry to examine.
               if (out_free) begin
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               rd_addr = ptr_next(addr_ff);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_found_ff  <= ld_found;
         rsp_stored_ff <= ld_stored;
         rsp_rec_ff    <= ld_rec;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_stored     = rsp_stored_ff;
   assign rsp_total_out  = rsp_rec_ff.total;
   assign rsp_year_out   = rsp_rec_ff.year;
   assign rsp_month_out  = rsp_rec_ff.month;
   assign rsp_day_out    = rsp_rec_ff.day;
   assign rsp_hour_out   = rsp_rec_ff.hour;
   assign rsp_minute_out = rsp_rec_ff.minute;

   // The save pointer moves only when a save completes with a write.
   a_save_ptr_move: assert property (@(posedge clock) disable iff (reset || $past(reset))
      !$stable(save_ptr_ff) |-> rsp_valid_ff && rsp_stored_ff)
      else $error("save pointer moved without a stored save");

   // The read pointer moves only when a read finds a record.
   a_read_ptr_move: assert property (@(posedge clock) disable iff (reset || $past(reset))
      !$stable(read_ptr_ff) |-> rsp_valid_ff && rsp_found_ff)
      else $error("read pointer moved without a found record");

   // A single result never reports both a found record and a stored save.
   a_found_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_stored_ff))
      else $error("result flags both found and stored");

   // A result without a found record carries a zero record.
   a_zero_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_rec_ff == '0)
      else $error("nonzero record on a result without a found record");

endmodule
